// File: design/rda_pkg.sv
// shared types and constants for the rda adagrad l1 weight update block
// no dependencies
package rda_pkg;

    localparam int COORD_W = 10;
    localparam int DATA_W  = 32;
    localparam int GSUM_W  = 48;
    localparam int SQ_W    = 64;
    localparam int PROD_W  = 80;

    // configuration register indexes
    localparam logic REG_STEP_SIZE    = 1'b0;
    localparam logic REG_L1_THRESHOLD = 1'b1;

    localparam logic [DATA_W-1:0] STEP_SIZE_RESET = 32'd65536;
    localparam logic [SQ_W-1:0]   SQ_RESET        = 64'd42950;

    localparam logic [GSUM_W-1:0] GSUM_MAX = {1'b0, {(GSUM_W-1){1'b1}}};
    localparam logic [GSUM_W-1:0] GSUM_MIN = {1'b1, {(GSUM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CHECK,
        ST_SQRT,
        ST_MUL0,
        ST_MUL1,
        ST_DIVCHK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// File: design/rda_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module rda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/rda_adagrad_l1_weight_update.sv
// sequence from accepted transaction to result: 1 read, 1 update, 1 check,
// 32 square root steps, 2 multiply, 1 range check, 32 divide steps, 1 output load;
// the divide steps are skipped when the quotient saturates, and the root, multiply and
// divide when the sum stays at or under the threshold; an out-of-range coordinate goes
// straight to the output load; the root and divider make one result bit per cycle
// throughput: one transaction at a time, the next taken once the result is in the output register
// reset: clears control at once, then sweeps all NUM_COORDS entries of both stores
// writing their start values; no input transaction is taken during the sweep
module rda_adagrad_l1_weight_update #(
    parameter int NUM_COORDS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rda_pkg::COORD_W-1:0]   coord,
    input  logic signed [rda_pkg::DATA_W-1:0] gradient,
    input  logic                          end_of_batch,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rda_pkg::COORD_W-1:0]   out_coord,
    output logic signed [rda_pkg::DATA_W-1:0] weight,
    output logic                          is_zero,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [rda_pkg::DATA_W-1:0]    cfg_data
);

    localparam int AW = (NUM_COORDS > 1) ? $clog2(NUM_COORDS) : 1;

    // control
    rda_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [4:0]      cnt_reg;
    logic            in_fire;
    logic            out_fire;
    logic            in_range;

    // configuration and iteration count
    logic [31:0] step_size_reg;
    logic [31:0] l1_threshold_reg;
    logic [31:0] iter_reg;

    // captured transaction
    logic [rda_pkg::COORD_W-1:0] coord_reg;
    logic signed [31:0]          grad_reg;
    logic                        eob_reg;
    logic                        inrange_reg;

    // datapath
    logic [63:0] sq_reg;
    logic [63:0] thr_reg;
    logic [47:0] absg_reg;
    logic        gpos_reg;
    logic        zero_reg;
    logic [47:0] d_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] one_reg;
    logic [31:0] div_reg;
    logic [79:0] prod_reg;
    logic [32:0] rem_reg;
    logic [31:0] q_reg;

    // output register
    logic                        out_valid_reg;
    logic [rda_pkg::COORD_W-1:0] out_coord_reg;
    logic [31:0]                 weight_reg;
    logic                        is_zero_reg;

    // memory ports
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [47:0]           gsum_wdata;
    logic [63:0]           sq_wdata;
    logic [47:0]           gsum_rdata;
    logic [63:0]           sq_rdata;

    // update arithmetic
    logic [31:0]        grad_mag;
    logic signed [48:0] gsum_wide;
    logic [47:0]        gsum_new;
    logic [64:0]        sq_wide;
    logic [63:0]        sq_new;
    logic [47:0]        absg_new;
    logic [64:0]        root_try;
    logic [33:0]        div_try;
    logic [32:0]        rem_shift;
    logic [31:0]        weight_calc;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign in_range = {7'd0, coord} < 17'(NUM_COORDS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rda_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(NUM_COORDS - 1))
                begin
                    state_next = rda_pkg::ST_IDLE;
                end
            end
            rda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_range ? rda_pkg::ST_READ : rda_pkg::ST_DONE;
                end
            end
            rda_pkg::ST_READ:   state_next = rda_pkg::ST_UPDATE;
            rda_pkg::ST_UPDATE: state_next = rda_pkg::ST_CHECK;
            rda_pkg::ST_CHECK:
            begin
                state_next = ({16'd0, absg_reg} <= thr_reg) ? rda_pkg::ST_DONE
                                                             : rda_pkg::ST_SQRT;
            end
            rda_pkg::ST_SQRT:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = rda_pkg::ST_MUL0;
                end
            end
            rda_pkg::ST_MUL0:   state_next = rda_pkg::ST_MUL1;
            rda_pkg::ST_MUL1:   state_next = rda_pkg::ST_DIVCHK;
            rda_pkg::ST_DIVCHK:
            begin
                state_next = (prod_reg[79:32] >= {16'd0, div_reg}) ? rda_pkg::ST_DONE
                                                                    : rda_pkg::ST_DIV;
            end
            rda_pkg::ST_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = rda_pkg::ST_DONE;
                end
            end
            rda_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = rda_pkg::ST_IDLE;
                end
            end
            default:            state_next = rda_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        case (state_reg)
            rda_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            rda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            rda_pkg::ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(coord_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // read-modify-write arithmetic on the coordinate's sums
    assign grad_mag  = grad_reg[31] ? 32'(-grad_reg) : grad_reg;
    assign gsum_wide = $signed({gsum_rdata[47], gsum_rdata})
                     + $signed({{17{grad_reg[31]}}, grad_reg});
    assign gsum_new  = (gsum_wide[48] != gsum_wide[47])
                     ? (gsum_wide[48] ? rda_pkg::GSUM_MIN : rda_pkg::GSUM_MAX)
                     : gsum_wide[47:0];
    assign sq_wide   = {1'b0, sq_rdata} + {1'b0, sq_reg};
    assign sq_new    = sq_wide[64] ? {64{1'b1}} : sq_wide[63:0];
    assign absg_new  = gsum_new[47] ? 48'(-gsum_new) : gsum_new;

    assign gsum_wdata = (state_reg == rda_pkg::ST_CLEAR) ? 48'd0 : gsum_new;
    assign sq_wdata   = (state_reg == rda_pkg::ST_CLEAR) ? rda_pkg::SQ_RESET : sq_new;

    // one root step and one divide step
    assign root_try  = {1'b0, res_reg} + {1'b0, one_reg};
    assign rem_shift = {rem_reg[31:0], prod_reg[31]};
    assign div_try   = {1'b0, rem_shift} - {2'b00, div_reg};

    // sign and saturation of the final weight
    always_comb
    begin
        weight_calc = 32'd0;
        if (inrange_reg && !zero_reg)
        begin
            if (gpos_reg)
            begin
                weight_calc = (q_reg > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q_reg);
            end
            else
            begin
                weight_calc = (q_reg > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_reg;
            end
        end
    end

    rda_ram #(.WIDTH(rda_pkg::GSUM_W), .DEPTH(NUM_COORDS)) u_gsum_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (gsum_wdata),
        .re    (in_fire),
        .raddr (AW'(coord)),
        .rdata (gsum_rdata)
    );

    rda_ram #(.WIDTH(rda_pkg::SQ_W), .DEPTH(NUM_COORDS)) u_sq_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (sq_wdata),
        .re    (in_fire),
        .raddr (AW'(coord)),
        .rdata (sq_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rda_pkg::ST_CLEAR;
            clr_addr_reg     <= '0;
            cnt_reg          <= '0;
            step_size_reg    <= rda_pkg::STEP_SIZE_RESET;
            l1_threshold_reg <= '0;
            iter_reg         <= 32'd1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rda_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == rda_pkg::ST_SQRT || state_reg == rda_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rda_pkg::REG_STEP_SIZE:    step_size_reg    <= cfg_data;
                    rda_pkg::REG_L1_THRESHOLD: l1_threshold_reg <= cfg_data;
                    default:                   step_size_reg    <= step_size_reg;
                endcase
            end
            // result leaves to the output register; the batch count advances here
            if (state_reg == rda_pkg::ST_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                if (eob_reg && iter_reg != 32'hFFFF_FFFF)
                begin
                    iter_reg <= iter_reg + 32'd1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            coord_reg   <= coord;
            grad_reg    <= gradient;
            eob_reg     <= end_of_batch;
            inrange_reg <= in_range;
            zero_reg    <= 1'b0;
        end
        case (state_reg)
            rda_pkg::ST_READ:
            begin
                sq_reg  <= 64'(grad_mag) * 64'(grad_mag);
                thr_reg <= 64'(iter_reg) * 64'(l1_threshold_reg);
            end
            rda_pkg::ST_UPDATE:
            begin
                absg_reg <= absg_new;
                gpos_reg <= !gsum_new[47] && (gsum_new != 48'd0);
                x_reg    <= sq_new;
                res_reg  <= '0;
                one_reg  <= 64'h4000_0000_0000_0000;
            end
            rda_pkg::ST_CHECK:
            begin
                zero_reg <= {16'd0, absg_reg} <= thr_reg;
                d_reg    <= absg_reg - thr_reg[47:0];
            end
            rda_pkg::ST_SQRT:
            begin
                if ({1'b0, x_reg} >= root_try)
                begin
                    x_reg   <= x_reg - root_try[63:0];
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            rda_pkg::ST_MUL0:
            begin
                // root settled at the end of the last step
                div_reg  <= (res_reg[31:0] == 32'd0) ? 32'd1 : res_reg[31:0];
                prod_reg <= {16'd0, 64'(step_size_reg) * 64'(d_reg[31:0])};
            end
            rda_pkg::ST_MUL1:
            begin
                prod_reg <= prod_reg + {48'(step_size_reg) * 48'(d_reg[47:32]), 32'd0};
            end
            rda_pkg::ST_DIVCHK:
            begin
                q_reg   <= 32'hFFFF_FFFF;
                rem_reg <= {1'b0, prod_reg[63:32]};
            end
            rda_pkg::ST_DIV:
            begin
                if (!div_try[33])
                begin
                    rem_reg <= div_try[32:0];
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
                prod_reg <= {prod_reg[79:32], prod_reg[30:0], 1'b0};
            end
            rda_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_coord_reg <= coord_reg;
                    weight_reg    <= weight_calc;
                    is_zero_reg   <= inrange_reg && zero_reg;
                end
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_coord = out_coord_reg;
    assign weight    = weight_reg;
    assign is_zero   = is_zero_reg;

endmodule

// File: design/rda_checker.sv
// port-level checks for the rda adagrad l1 weight update block, with its bind
// depends on rda_pkg and on the top level's ports
module rda_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rda_pkg::COORD_W-1:0]   out_coord,
    input logic [rda_pkg::DATA_W-1:0]    weight,
    input logic                          is_zero
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(out_coord))
        else $error("result changed while stalled");

    // a thresholded result always reports zero
    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_zero |-> weight == '0)
        else $error("is_zero with nonzero weight");

    // one transaction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back to back input accept");

    // an accepted transaction passes through the done state before its result is shown
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after accept");

endmodule

bind rda_adagrad_l1_weight_update rda_checker u_rda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_coord (out_coord),
    .weight    (weight),
    .is_zero   (is_zero)
);

// File: dv/rda_adagrad_l1_weight_update_tb.sv
// self-checking testbench for rda_adagrad_l1_weight_update: directed and random gradient
// transactions checked field by field against an in-bench weight predictor
// depends on rda_pkg and the rda_adagrad_l1_weight_update rtl
module rda_adagrad_l1_weight_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOORD = 1024;
    localparam int SLOW   = 80;   // longest per-item latency plus margin

    typedef struct packed {
        logic [rda_pkg::COORD_W-1:0] coord;
        logic [rda_pkg::DATA_W-1:0]  weight;
        logic                        is_zero;
    } weight_result_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic [rda_pkg::COORD_W-1:0] coord;
    logic signed [rda_pkg::DATA_W-1:0] gradient;
    logic end_of_batch;
    logic out_valid, out_ready;
    logic [rda_pkg::COORD_W-1:0] out_coord;
    logic signed [rda_pkg::DATA_W-1:0] weight;
    logic is_zero;
    logic cfg_we;
    logic cfg_index;
    logic [rda_pkg::DATA_W-1:0] cfg_data;

    rda_adagrad_l1_weight_update u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .coord(coord),
        .gradient(gradient), .end_of_batch(end_of_batch),
        .out_valid(out_valid), .out_ready(out_ready), .out_coord(out_coord),
        .weight(weight), .is_zero(is_zero),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state: mirrors the block's stores and registers
    logic [31:0]        alpha;
    logic [31:0]        lambda;
    logic signed [47:0] gsum_model [NCOORD];
    logic [63:0]        hsum_model [NCOORD];
    logic [31:0]        iter_model;

    weight_result_t expected_weights[$];
    int  mismatches = 0;
    bit  recv_hold  = 0;   // forces a long receiver hold-off
    bit  recv_nostall = 0; // stretch with no receiver idling

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("rda_adagrad_l1_weight_update regression: fail");
        $finish;
    end

    // truncated integer square root, one result bit per pass
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // works out one result and advances predictor state
    function automatic weight_result_t predict_weight(input logic [9:0] c,
                                                      input logic [31:0] g_raw,
                                                      input logic eob);
        weight_result_t r;
        logic signed [63:0] g, gs;
        logic [63:0] mag, sq, h, abs_g, thr, s;
        logic [127:0] quot;
        r.coord   = c;
        r.weight  = 0;
        r.is_zero = 0;
        g   = $signed(g_raw);
        mag = (g < 0) ? -g : g;
        sq  = mag * mag;
        gs  = $signed(gsum_model[c]) + g;
        if (gs > 64'sh7FFF_FFFF_FFFF) gs = 64'sh7FFF_FFFF_FFFF;
        if (gs < -64'sh8000_0000_0000) gs = -64'sh8000_0000_0000;
        gsum_model[c] = gs[47:0];
        h = hsum_model[c];
        h = (h > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : h + sq;
        hsum_model[c] = h;
        abs_g = (gs < 0) ? -gs : gs;
        thr   = 64'(iter_model) * 64'(lambda);
        if (abs_g <= thr)
            r.is_zero = 1;
        else
        begin
            s = int_sqrt(h);
            if (s == 0) s = 1;
            quot = (128'(alpha) * 128'(abs_g - thr)) / 128'(s);
            if (gs > 0)
            begin
                if (quot > 128'h8000_0000) quot = 128'h8000_0000;
                r.weight = -quot[31:0];
            end
            else
            begin
                if (quot > 128'h7FFF_FFFF) quot = 128'h7FFF_FFFF;
                r.weight = quot[31:0];
            end
        end
        if (eob && iter_model != 32'hFFFF_FFFF) iter_model++;
        return r;
    endfunction

    // result checker with random receiver stalls
    initial begin
        weight_result_t exp_r;
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (recv_hold) out_ready <= 0;
            else
            begin
                gap = recv_nostall ? 0 : $urandom_range(0, 18);
                if (gap != 0)
                begin
                    out_ready <= 0;
                    repeat (gap) @(negedge clk);
                end
                out_ready <= 1;
                do @(posedge clk); while (!(out_valid && out_ready) && !recv_hold);
                if (out_valid && out_ready)
                begin
                    if (expected_weights.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected transaction coord=%0d weight=%0d",
                                     out_coord, weight);
                    end
                    else
                    begin
                        exp_r = expected_weights.pop_front();
                        if (out_coord !== exp_r.coord || weight !== exp_r.weight ||
                            is_zero !== exp_r.is_zero)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("mismatch exp coord=%0d w=%0d z=%0d got %0d %0d %0d",
                                         exp_r.coord, $signed(exp_r.weight), exp_r.is_zero,
                                         out_coord, weight, is_zero);
                        end
                    end
                end
            end
        end
    end

    // offers one gradient transaction after a random gap, then waits for acceptance
    task automatic send_gradient(input logic [9:0] c, input logic [31:0] g, input logic eob,
                                 input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge clk);
        in_valid     = 1;
        coord        = c;
        gradient     = g;
        end_of_batch = eob;
        do @(posedge clk); while (!(in_valid && in_ready));
        expected_weights = {expected_weights, predict_weight(c, g, eob)};
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic wait_drained();
        while (expected_weights.size() != 0) @(negedge clk);
        repeat (SLOW) @(negedge clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == rda_pkg::REG_STEP_SIZE) alpha = val;
        else lambda = val;
    endtask

    function automatic logic [31:0] rand_gradient();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // extremes of fields, zero sum, top-of-range coords, saturation of square sums and weights, zero step
    task automatic test_directed();
        send_gradient(0, 0, 0);                    // zero sum gives zero
        send_gradient(1023, 32'h0001_0000, 0);
        send_gradient(1023, 32'hFFFF_0000, 1);     // back to zero sum
        send_gradient(5, 32'h7FFF_FFFF, 0);
        send_gradient(6, 32'h8000_0000, 1);
        send_gradient(7, 32'h0000_0001, 0);        // tiny magnitude
        for (int i = 0; i < 6; i++) send_gradient(8, 32'h8000_0000, 0); // big sums
        for (int i = 0; i < 6; i++) send_gradient(9, 32'h7FFF_FFFF, 1);
        send_gradient(10, 32'h0000_8000, 0);
        send_gradient(512, 32'h5555_5555, 1);
        send_gradient(513, 32'hAAAA_AAAA, 0);
        wait_drained();
        write_reg(rda_pkg::REG_STEP_SIZE, 32'hFFFF_FFFF);   // saturate weights
        send_gradient(8, 32'h8000_0000, 0);
        send_gradient(9, 32'h7FFF_FFFF, 0);
        send_gradient(11, 32'h0000_0100, 0);
        wait_drained();
        write_reg(rda_pkg::REG_STEP_SIZE, 0);
        send_gradient(12, 32'h1234_5678, 0);
        wait_drained();
    endtask

    // random content under varied threshold and step size settings
    task automatic test_random(input int count, input logic [31:0] a, input logic [31:0] l);
        write_reg(rda_pkg::REG_STEP_SIZE, a);
        write_reg(rda_pkg::REG_L1_THRESHOLD, l);
        for (int i = 0; i < count; i++)
        begin
            // mostly a small coord pool so sums build up
            send_gradient(10'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 15)),
                          rand_gradient(), $urandom_range(0, 7) == 0);
        end
        wait_drained();
    endtask

    // receiver holds off while sender keeps offering; after a drain, a run with no gaps on either side
    task automatic test_backpressure();
        recv_hold = 1;
        fork
            begin
                for (int i = 0; i < 8; i++)
                    send_gradient(10'($urandom_range(0, 15)), rand_gradient(), 0, 1);
            end
            begin
                repeat (600) @(negedge clk);
                recv_hold = 0;
            end
        join
        wait_drained();
        recv_nostall = 1;
        for (int i = 0; i < 10; i++)
            send_gradient(10'($urandom_range(0, 15)), rand_gradient(), 1, 1);
        wait_drained();
        recv_nostall = 0;
    endtask

    initial begin
        in_valid = 0; coord = 0; gradient = 0; end_of_batch = 0;
        cfg_we = 0; cfg_index = 0; cfg_data = 0;
        alpha = rda_pkg::STEP_SIZE_RESET; lambda = 0; iter_model = 1;
        for (int i = 0; i < NCOORD; i++)
        begin
            gsum_model[i] = 0;
            hsum_model[i] = rda_pkg::SQ_RESET;
        end
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        test_directed();
        test_random(100, 32'h0001_0000, 32'h0000_0100);
        test_random(100, 32'h0000_4000, 0);
        test_random(80, $urandom, 32'h0000_0010);
        test_random(60, 32'h0001_0000, 32'hFFFF_FFFF);
        test_backpressure();
        test_random(40, 32'hFFFF_FFFF, $urandom_range(0, 32'h0010_0000));
        wait_drained();
        if (mismatches == 0 && expected_weights.size() == 0)
            $display("rda_adagrad_l1_weight_update regression: pass");
        else
            $display("rda_adagrad_l1_weight_update regression: fail");
        $finish;
    end

endmodule
